### sv/tpd_pkg.sv
// ----------------------------------------------------------------------------
// tpd_pkg
// Shared types and constants of the tour point distance pipeline.
// ----------------------------------------------------------------------------
package tpd_pkg;

  // width and ceiling of the distance result
  localparam int unsigned DIST_W = 17;
  localparam logic [DIST_W-1:0] DIST_MAX = 17'h1FFFF;

  // pseudo-euclidean scale of the att metric
  localparam logic [4:0] ATT_SCALE = 5'd10;

  // distance metric selected by the mode register
  typedef enum logic [1:0] {
    MODE_EUC_2D  = 2'd0,
    MODE_CEIL_2D = 2'd1,
    MODE_EUC_3D  = 2'd2,
    MODE_ATT     = 2'd3
  } norm_mode_e;

  // control that travels with every pipeline stage
  typedef struct packed {
    logic       vld;
    norm_mode_e mode;
  } meta_t;

endpackage

### sv/tpd_pt_if.sv
// ----------------------------------------------------------------------------
// tpd_pt_if
// Handshake channel carrying one point pair word.
// ----------------------------------------------------------------------------
interface tpd_pt_if #(
  parameter int COORD_BITS = 24
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] x_a;
  logic signed [COORD_BITS-1:0] y_a;
  logic signed [COORD_BITS-1:0] z_a;
  logic signed [COORD_BITS-1:0] x_b;
  logic signed [COORD_BITS-1:0] y_b;
  logic signed [COORD_BITS-1:0] z_b;

  modport source (output valid, x_a, y_a, z_a, x_b, y_b, z_b, input ready);
  modport sink (input valid, x_a, y_a, z_a, x_b, y_b, z_b, output ready);
endinterface

### sv/tpd_dist_if.sv
// ----------------------------------------------------------------------------
// tpd_dist_if
// Handshake channel carrying one distance word.
// ----------------------------------------------------------------------------
interface tpd_dist_if ();
  logic                         valid;
  logic                         ready;
  logic [tpd_pkg::DIST_W-1:0]   distance;

  modport source (output valid, distance, input ready);
  modport sink (input valid, distance, output ready);
endinterface

### sv/tpd_sqsum.sv
// ----------------------------------------------------------------------------
// tpd_sqsum
// Three stages: absolute differences, squares, sum of squares.
// ----------------------------------------------------------------------------
module tpd_sqsum #(
  parameter int COORD_BITS = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  tpd_pkg::meta_t                meta_i,
  input  logic signed [COORD_BITS-1:0]  x_a_i,
  input  logic signed [COORD_BITS-1:0]  y_a_i,
  input  logic signed [COORD_BITS-1:0]  z_a_i,
  input  logic signed [COORD_BITS-1:0]  x_b_i,
  input  logic signed [COORD_BITS-1:0]  y_b_i,
  input  logic signed [COORD_BITS-1:0]  z_b_i,
  output tpd_pkg::meta_t                meta_o,
  output logic [2*COORD_BITS+1:0]       sum_o
);

  localparam int SW = 2 * COORD_BITS + 2;
  localparam int QW = 2 * COORD_BITS;

  tpd_pkg::meta_t meta1_q, meta2_q, meta3_q;
  logic [COORD_BITS-1:0] dx_q, dy_q, dz_q;
  logic [QW-1:0] sqx_d, sqy_d, sqz_d;
  logic [QW-1:0] sqx_q, sqy_q, sqz_q;
  logic [SW-1:0] sum_d, sum_q;

  // magnitude of a difference, never above 2^COORD_BITS - 1
  function automatic logic [COORD_BITS-1:0] abs_diff(
    input logic signed [COORD_BITS-1:0] a,
    input logic signed [COORD_BITS-1:0] b
  );
    logic signed [COORD_BITS:0] d;
    d = (COORD_BITS+1)'(a) - (COORD_BITS+1)'(b);
    if (d[COORD_BITS]) begin
      d = -d;
    end
    return d[COORD_BITS-1:0];
  endfunction

  // squares, z only counted in 3d mode
  always_comb begin
    sqx_d = QW'(dx_q) * QW'(dx_q);
    sqy_d = QW'(dy_q) * QW'(dy_q);
    if (meta1_q.mode == tpd_pkg::MODE_EUC_3D) begin
      sqz_d = QW'(dz_q) * QW'(dz_q);
    end else begin
      sqz_d = '0;
    end
  end

  // sum of squares
  assign sum_d = SW'(sqx_q) + SW'(sqy_q) + SW'(sqz_q);

  // valid bits and mode
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      meta1_q <= '0;
      meta2_q <= '0;
      meta3_q <= '0;
    end else if (en_i) begin
      meta1_q <= meta_i;
      meta2_q <= meta1_q;
      meta3_q <= meta2_q;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dx_q  <= abs_diff(x_a_i, x_b_i);
      dy_q  <= abs_diff(y_a_i, y_b_i);
      dz_q  <= abs_diff(z_a_i, z_b_i);
      sqx_q <= sqx_d;
      sqy_q <= sqy_d;
      sqz_q <= sqz_d;
      sum_q <= sum_d;
    end
  end

  assign meta_o = meta3_q;
  assign sum_o  = sum_q;

endmodule

### sv/tpd_att_div.sv
// ----------------------------------------------------------------------------
// tpd_att_div
// Ceiling division of the sum by 10 * 4^FRAC_BITS for the att metric,
// eight quotient bits a stage, then selection of the square root operand.
// ----------------------------------------------------------------------------
module tpd_att_div #(
  parameter int COORD_BITS = 24,
  parameter int FRAC_BITS  = 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  tpd_pkg::meta_t          meta_i,
  input  logic [2*COORD_BITS+1:0] sum_i,
  output tpd_pkg::meta_t          meta_o,
  output logic [2*COORD_BITS+1:0] op_o
);

  localparam int SW    = 2 * COORD_BITS + 2;
  localparam int TWO_F = 2 * FRAC_BITS;
  localparam int SHW   = (SW > TWO_F) ? SW - TWO_F : 1;
  localparam int NDS   = (SHW + 7) / 8;
  localparam int PW    = NDS * 8;
  localparam logic [SW-1:0] LOW_MASK =
    (TWO_F >= SW) ? {SW{1'b1}} : ((SW'(1) << TWO_F) - SW'(1));

  // stage 0 is the split register, stages 1..NDS the division steps
  tpd_pkg::meta_t   meta_q [NDS+1];
  logic [SW-1:0]    sum_q  [NDS+1];
  logic [PW-1:0]    wrd_q  [NDS+1];
  logic [3:0]       rem_q  [NDS+1];
  logic             nz_q   [NDS+1];

  tpd_pkg::meta_t   op_meta_q;
  logic [SW-1:0]    op_q;
  logic [PW-1:0]    ceil_quo;
  logic [SW-1:0]    op_d;

  // split into whole part and sticky fraction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      meta_q[0] <= '0;
    end else if (en_i) begin
      meta_q[0] <= meta_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum_q[0] <= sum_i;
      wrd_q[0] <= PW'(sum_i >> TWO_F);
      rem_q[0] <= '0;
      nz_q[0]  <= |(sum_i & LOW_MASK);
    end
  end

  // long division by ten, quotient bits replace dividend bits in place
  for (genvar k = 1; k <= NDS; k++) begin : g_div
    logic [PW-1:0] wrd_d;
    logic [3:0]    rem_d;

    always_comb begin : div_step
      logic [4:0] part;
      wrd_d = wrd_q[k-1];
      rem_d = rem_q[k-1];
      for (int b = 0; b < 8; b++) begin
        part = {rem_d, wrd_d[PW-1-8*(k-1)-b]};
        if (part >= tpd_pkg::ATT_SCALE) begin
          rem_d = 4'(part - tpd_pkg::ATT_SCALE);
          wrd_d[PW-1-8*(k-1)-b] = 1'b1;
        end else begin
          rem_d = part[3:0];
          wrd_d[PW-1-8*(k-1)-b] = 1'b0;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        meta_q[k] <= '0;
      end else if (en_i) begin
        meta_q[k] <= meta_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sum_q[k] <= sum_q[k-1];
        wrd_q[k] <= wrd_d;
        rem_q[k] <= rem_d;
        nz_q[k]  <= nz_q[k-1];
      end
    end
  end

  // round the quotient up and pick the root operand
  assign ceil_quo = wrd_q[NDS] + PW'((rem_q[NDS] != 4'd0) || nz_q[NDS]);

  always_comb begin
    if (meta_q[NDS].mode == tpd_pkg::MODE_ATT) begin
      op_d = SW'(ceil_quo);
    end else begin
      op_d = sum_q[NDS];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_meta_q <= '0;
    end else if (en_i) begin
      op_meta_q <= meta_q[NDS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      op_q <= op_d;
    end
  end

  assign meta_o = op_meta_q;
  assign op_o   = op_q;

endmodule

### sv/tpd_isqrt.sv
// ----------------------------------------------------------------------------
// tpd_isqrt
// Pipelined integer square root, one root bit a stage, with remainder.
// ----------------------------------------------------------------------------
module tpd_isqrt #(
  parameter int COORD_BITS = 24
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  tpd_pkg::meta_t          meta_i,
  input  logic [2*COORD_BITS+1:0] op_i,
  output tpd_pkg::meta_t          meta_o,
  output logic [COORD_BITS:0]     root_o,
  output logic [COORD_BITS+1:0]   rem_o
);

  localparam int SW = 2 * COORD_BITS + 2;
  localparam int RW = COORD_BITS + 1;

  tpd_pkg::meta_t meta_q [RW];
  logic [SW-1:0]  rad_q  [RW];
  logic [RW:0]    rem_q  [RW];
  logic [RW-1:0]  root_q [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    tpd_pkg::meta_t meta_in;
    logic [SW-1:0]  rad_in;
    logic [RW:0]    rem_in;
    logic [RW-1:0]  root_in;
    logic [RW+2:0]  acc;
    logic [RW+2:0]  trial;
    logic [RW:0]    rem_d;
    logic [RW-1:0]  root_d;

    // stage input taps
    if (k == 0) begin : g_first
      assign meta_in = meta_i;
      assign rad_in  = op_i;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign meta_in = meta_q[k-1];
      assign rad_in  = rad_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
    end

    // trial subtract of 4*root + 1 from the shifted remainder
    assign acc   = {rem_in, rad_in[SW-1:SW-2]};
    assign trial = {1'b0, root_in, 2'b01};

    always_comb begin
      if (acc >= trial) begin
        rem_d  = (RW+1)'(acc - trial);
        root_d = {root_in[RW-2:0], 1'b1};
      end else begin
        rem_d  = (RW+1)'(acc);
        root_d = {root_in[RW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        meta_q[k] <= '0;
      end else if (en_i) begin
        meta_q[k] <= meta_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[k]  <= rad_in << 2;
        rem_q[k]  <= rem_d;
        root_q[k] <= root_d;
      end
    end
  end

  assign meta_o = meta_q[RW-1];
  assign root_o = root_q[RW-1];
  assign rem_o  = rem_q[RW-1];

endmodule

### sv/tpd_round.sv
// ----------------------------------------------------------------------------
// tpd_round
// Metric rounding of the root, saturation and the output register.
// ----------------------------------------------------------------------------
module tpd_round #(
  parameter int COORD_BITS = 24,
  parameter int FRAC_BITS  = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  tpd_pkg::meta_t              meta_i,
  input  logic [COORD_BITS:0]         root_i,
  input  logic [COORD_BITS+1:0]       rem_i,
  output logic                        valid_o,
  output logic [tpd_pkg::DIST_W-1:0]  distance_o
);

  localparam int RW = COORD_BITS + 1;
  localparam int VW = RW + 2;
  localparam int CW = (VW > tpd_pkg::DIST_W) ? VW : tpd_pkg::DIST_W;

  logic [RW:0]                  twice_root;
  logic [VW-1:0]                half_v, ceil_v, att_v, val;
  logic                         sat;
  logic [tpd_pkg::DIST_W-1:0]   dist_d;
  logic                         valid_q;
  logic [tpd_pkg::DIST_W-1:0]   dist_q;

  // floor(sqrt(4s)): remainder above root means the half step is passed
  assign twice_root = {root_i, 1'b0} + (RW+1)'(rem_i > (RW+1)'(root_i));

  // candidates for each metric
  assign half_v = (VW'(twice_root) + (VW'(1) << FRAC_BITS)) >> (FRAC_BITS + 1);
  assign ceil_v = (rem_i == '0)
                ? ((VW'(root_i) + (VW'(1) << FRAC_BITS) - VW'(1)) >> FRAC_BITS)
                : (VW'(root_i >> FRAC_BITS) + VW'(1));
  assign att_v  = VW'(root_i) + VW'(rem_i != '0);

  always_comb begin
    case (meta_i.mode)
      tpd_pkg::MODE_EUC_2D:  val = half_v;
      tpd_pkg::MODE_CEIL_2D: val = ceil_v;
      tpd_pkg::MODE_EUC_3D:  val = half_v;
      tpd_pkg::MODE_ATT:     val = att_v;
      default:               val = half_v;
    endcase
  end

  // clamp to the result range
  assign sat    = CW'(val) > CW'(tpd_pkg::DIST_MAX);
  assign dist_d = sat ? tpd_pkg::DIST_MAX : tpd_pkg::DIST_W'(val);

  // output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= meta_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dist_q <= dist_d;
    end
  end

  assign valid_o    = valid_q;
  assign distance_o = dist_q;

endmodule

### sv/tour_point_distance.sv
// ----------------------------------------------------------------------------
// tour_point_distance
// Integer distance of a point pair in the euclidean, ceiling, 3d and att
// routing metrics, fully pipelined.
// ----------------------------------------------------------------------------
// throughput: one word per cycle; the whole pipeline holds while the output
//   word waits, so a stall loses and repeats nothing
// reset: clears every valid bit and sets the mode register to euclidean rounded
// ----------------------------------------------------------------------------
module tour_point_distance #(
  parameter int COORD_BITS = 24,
  parameter int FRAC_BITS  = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_data_i,
  tpd_pt_if.sink       pt_in,
  tpd_dist_if.source   dist_out
);

  localparam int SW = 2 * COORD_BITS + 2;
  localparam int RW = COORD_BITS + 1;

  tpd_pkg::norm_mode_e mode_q;
  tpd_pkg::meta_t      meta_in, meta_sq, meta_op, meta_rt;
  logic                en;
  logic [SW-1:0]       sum;
  logic [SW-1:0]       op;
  logic [RW-1:0]       root;
  logic [RW:0]         rem;

  // mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= tpd_pkg::MODE_EUC_2D;
    end else if (cfg_we_i) begin
      mode_q <= tpd_pkg::norm_mode_e'(cfg_data_i);
    end
  end

  // pipeline advances whenever the output register is free or drained
  assign en          = !dist_out.valid || dist_out.ready;
  assign pt_in.ready = en;
  assign meta_in     = '{vld: pt_in.valid, mode: mode_q};

  tpd_sqsum #(
    .COORD_BITS (COORD_BITS)
  ) u_sqsum (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .meta_i (meta_in),
    .x_a_i  (pt_in.x_a),
    .y_a_i  (pt_in.y_a),
    .z_a_i  (pt_in.z_a),
    .x_b_i  (pt_in.x_b),
    .y_b_i  (pt_in.y_b),
    .z_b_i  (pt_in.z_b),
    .meta_o (meta_sq),
    .sum_o  (sum)
  );

  tpd_att_div #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_att_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .meta_i (meta_sq),
    .sum_i  (sum),
    .meta_o (meta_op),
    .op_o   (op)
  );

  tpd_isqrt #(
    .COORD_BITS (COORD_BITS)
  ) u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .meta_i (meta_op),
    .op_i   (op),
    .meta_o (meta_rt),
    .root_o (root),
    .rem_o  (rem)
  );

  tpd_round #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_round (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .meta_i     (meta_rt),
    .root_i     (root),
    .rem_i      (rem),
    .valid_o    (dist_out.valid),
    .distance_o (dist_out.distance)
  );

endmodule
